// ===== src/stte_pkg.sv =====
// Package for the soft timer table engine.
// Holds command, result and status codes, entry layout and the sequencer state type.
// No dependencies.
package stte_pkg;

    localparam logic [2:0] KIND_TICK     = 3'd0;
    localparam logic [2:0] KIND_START_OS = 3'd1;
    localparam logic [2:0] KIND_STOP_OS  = 3'd2;
    localparam logic [2:0] KIND_START_PD = 3'd3;
    localparam logic [2:0] KIND_STOP_PD  = 3'd4;
    localparam logic [2:0] KIND_START_CT = 3'd5;
    localparam logic [2:0] KIND_STOP_CT  = 3'd6;
    localparam logic [2:0] KIND_NONE     = 3'd7;

    localparam logic [1:0] RK_FIRE   = 2'd0;
    localparam logic [1:0] RK_RUN    = 2'd1;
    localparam logic [1:0] RK_STATUS = 2'd2;

    localparam logic [1:0] TBL_OS = 2'd0;
    localparam logic [1:0] TBL_PD = 2'd1;
    localparam logic [1:0] TBL_CT = 2'd2;

    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_UNCHANGED = 2'd1;
    localparam logic [1:0] STAT_FULL      = 2'd2;
    localparam logic [1:0] STAT_NULL      = 2'd3;

    localparam int MAX_RESULTS = 25;
    localparam int FIRE_CNT_W  = 5;

    // entry: start [31:0], period [47:32], task [55:48], remaining [71:56] (counted only)
    localparam int ENTRY_W    = 56;
    localparam int CT_ENTRY_W = 72;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_EV,
        S_ACT,
        S_RUN,
        S_STAT,
        S_FIN
    } state_t;

endpackage

// ===== src/stte_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module stte_ram #(
    parameter int WIDTH = 56,
    parameter int DEPTH = 8
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== src/soft_timer_table_engine.sv =====
// Soft timer table engine, top level: sequencer, valid bits and result staging.
// Depends on stte_pkg and stte_ram (one RAM per timer table).
//
// Usage: commands enter on the s_axis channel (tuser = kind, tdata = task id,
// period, repeat count). Results leave on m_axis (tuser = result kind, source
// table; tdata = task, status; tlast marks the final result of a command).
// One command is processed at a time; s_axis_tready is high only when idle.
// A tick walks the three tables slot by slot: an empty slot is passed over in
// S_SCAN_RD; an armed slot is read from RAM there, then evaluated and written
// back in S_SCAN_EV, where a fire may wait for room to stage its result.
// Start and stop commands search their table the same way, stopping at the
// matching slot, then update the table in S_ACT and report; a null task or a
// counted start with a repeat count of 0 or 1 skips the search.
// Each result is held one stage back so tlast can be set on the final one; it
// reaches m_axis when the next result is staged or, for the final one, when the
// command closes in S_FIN.
// A stalled receiver stalls the sequencer only when a new result must be
// staged or the final one flushed; table updates otherwise proceed.
// Reset clears the state, tick counter, all valid bits and the staged and output
// valid flags; RAM contents are only read behind a set valid bit.
module soft_timer_table_engine
    import stte_pkg::*;
#(
    parameter int ONESHOT_SLOTS  = 8,
    parameter int PERIODIC_SLOTS = 8,
    parameter int COUNTED_SLOTS  = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // task_id[7:0], period_ms[23:8], repeat_count[39:24]
    input  logic [2:0]  s_axis_tuser,   // kind[2:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // fired_task[7:0], status[9:8], zero[15:10]
    output logic [3:0]  m_axis_tuser,   // result_kind[1:0], source_table[3:2]
    output logic        m_axis_tlast
);

    localparam int MAXS_A = (ONESHOT_SLOTS > PERIODIC_SLOTS) ? ONESHOT_SLOTS : PERIODIC_SLOTS;
    localparam int MAXS   = (MAXS_A > COUNTED_SLOTS) ? MAXS_A : COUNTED_SLOTS;
    localparam int SLOT_W = (MAXS > 1) ? $clog2(MAXS) : 1;
    localparam int OS_AW  = (ONESHOT_SLOTS > 1) ? $clog2(ONESHOT_SLOTS) : 1;
    localparam int PD_AW  = (PERIODIC_SLOTS > 1) ? $clog2(PERIODIC_SLOTS) : 1;
    localparam int CT_AW  = (COUNTED_SLOTS > 1) ? $clog2(COUNTED_SLOTS) : 1;

    state_t state_reg, state_next;
    logic [2:0]  kind_reg, kind_next;
    logic [7:0]  tid_reg, tid_next;
    logic [15:0] per_reg, per_next;
    logic [15:0] cnt_reg, cnt_next;
    logic [31:0] tick_reg, tick_next;
    logic [1:0]  tbl_reg, tbl_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic        tick_mode_reg, tick_mode_next;
    logic [FIRE_CNT_W-1:0] fire_cnt_reg, fire_cnt_next;
    logic        found_reg, found_next;
    logic [SLOT_W-1:0] found_slot_reg, found_slot_next;
    logic [15:0] found_period_reg, found_period_next;
    logic [15:0] found_rem_reg, found_rem_next;
    logic [1:0]  st_reg, st_next;
    logic [ONESHOT_SLOTS-1:0]  os_valid_reg, os_valid_next;
    logic [PERIODIC_SLOTS-1:0] pd_valid_reg, pd_valid_next;
    logic [COUNTED_SLOTS-1:0]  ct_valid_reg, ct_valid_next;

    logic        pend_valid_reg, pend_valid_next;
    logic [1:0]  pend_rk_reg, pend_rk_next;
    logic [1:0]  pend_tbl_reg, pend_tbl_next;
    logic [7:0]  pend_task_reg, pend_task_next;
    logic [1:0]  pend_st_reg, pend_st_next;
    logic        out_valid_reg, out_valid_next;
    logic [1:0]  out_rk_reg, out_rk_next;
    logic [1:0]  out_tbl_reg, out_tbl_next;
    logic [7:0]  out_task_reg, out_task_next;
    logic [1:0]  out_st_reg, out_st_next;
    logic        out_last_reg, out_last_next;

    logic [ENTRY_W-1:0]    os_rdata, pd_rdata;
    logic [CT_ENTRY_W-1:0] ct_rdata;
    logic [CT_ENTRY_W-1:0] wr_data;
    logic [SLOT_W-1:0]     wr_idx;
    logic                  wr_en;

    logic [31:0] cur_start;
    logic [15:0] cur_period;
    logic [7:0]  cur_task;
    logic [15:0] cur_rem;
    logic [MAXS-1:0] cur_valid;
    logic [MAXS-1:0] free_mask;
    logic        free_ok;
    logic [SLOT_W-1:0] free_idx;
    logic [SLOT_W-1:0] last_slot;
    logic        expired;
    logic [31:0] elapsed;
    logic [15:0] rem_dec;
    logic        out_free, can_emit;
    logic        in_acc;
    logic        clr_en, set_en;
    logic [SLOT_W-1:0] clr_idx, set_idx;
    logic        emit_en, flush_en;
    logic [1:0]  emit_rk, emit_tbl, emit_st;
    logic [7:0]  emit_task;
    logic        adv;

    stte_ram #(.WIDTH(ENTRY_W), .DEPTH(ONESHOT_SLOTS)) u_os_ram (
        .clk   (clk),
        .we    (wr_en && tbl_reg == TBL_OS),
        .waddr (wr_idx[OS_AW-1:0]),
        .wdata (wr_data[ENTRY_W-1:0]),
        .raddr (slot_reg[OS_AW-1:0]),
        .rdata (os_rdata)
    );

    stte_ram #(.WIDTH(ENTRY_W), .DEPTH(PERIODIC_SLOTS)) u_pd_ram (
        .clk   (clk),
        .we    (wr_en && tbl_reg == TBL_PD),
        .waddr (wr_idx[PD_AW-1:0]),
        .wdata (wr_data[ENTRY_W-1:0]),
        .raddr (slot_reg[PD_AW-1:0]),
        .rdata (pd_rdata)
    );

    stte_ram #(.WIDTH(CT_ENTRY_W), .DEPTH(COUNTED_SLOTS)) u_ct_ram (
        .clk   (clk),
        .we    (wr_en && tbl_reg == TBL_CT),
        .waddr (wr_idx[CT_AW-1:0]),
        .wdata (wr_data),
        .raddr (slot_reg[CT_AW-1:0]),
        .rdata (ct_rdata)
    );

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign can_emit      = !pend_valid_reg || out_free;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'd0, out_st_reg, out_task_reg};
    assign m_axis_tuser  = {out_tbl_reg, out_rk_reg};
    assign m_axis_tlast  = out_last_reg;

    // current table view
    always_comb
    begin
        cur_valid = '1;
        case (tbl_reg)
            TBL_OS:
            begin
                cur_start  = os_rdata[31:0];
                cur_period = os_rdata[47:32];
                cur_task   = os_rdata[55:48];
                cur_rem    = 16'd0;
                cur_valid[ONESHOT_SLOTS-1:0] = os_valid_reg;
                last_slot  = SLOT_W'(ONESHOT_SLOTS - 1);
            end
            TBL_PD:
            begin
                cur_start  = pd_rdata[31:0];
                cur_period = pd_rdata[47:32];
                cur_task   = pd_rdata[55:48];
                cur_rem    = 16'd0;
                cur_valid[PERIODIC_SLOTS-1:0] = pd_valid_reg;
                last_slot  = SLOT_W'(PERIODIC_SLOTS - 1);
            end
            default:
            begin
                cur_start  = ct_rdata[31:0];
                cur_period = ct_rdata[47:32];
                cur_task   = ct_rdata[55:48];
                cur_rem    = ct_rdata[71:56];
                cur_valid[COUNTED_SLOTS-1:0] = ct_valid_reg;
                last_slot  = SLOT_W'(COUNTED_SLOTS - 1);
            end
        endcase
    end

    assign elapsed = tick_reg - cur_start;
    assign expired = elapsed >= {16'd0, cur_period};
    assign rem_dec = cur_rem - 16'd1;

    // lowest free slot, with the matched slot treated as freed
    always_comb
    begin
        free_mask = cur_valid;
        if (found_reg)
        begin
            free_mask[found_slot_reg] = 1'b0;
        end
        free_ok  = 1'b0;
        free_idx = '0;
        for (int j = MAXS - 1; j >= 0; j--)
        begin
            if (!free_mask[j])
            begin
                free_ok  = 1'b1;
                free_idx = SLOT_W'(j);
            end
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        kind_next         = kind_reg;
        tid_next          = tid_reg;
        per_next          = per_reg;
        cnt_next          = cnt_reg;
        tick_next         = tick_reg;
        tbl_next          = tbl_reg;
        slot_next         = slot_reg;
        tick_mode_next    = tick_mode_reg;
        fire_cnt_next     = fire_cnt_reg;
        found_next        = found_reg;
        found_slot_next   = found_slot_reg;
        found_period_next = found_period_reg;
        found_rem_next    = found_rem_reg;
        st_next           = st_reg;
        clr_en    = 1'b0;
        set_en    = 1'b0;
        clr_idx   = slot_reg;
        set_idx   = free_idx;
        wr_en     = 1'b0;
        wr_idx    = slot_reg;
        wr_data   = {cur_rem, cur_task, cur_period, tick_reg};
        emit_en   = 1'b0;
        flush_en  = 1'b0;
        emit_rk   = RK_FIRE;
        emit_tbl  = tbl_reg;
        emit_task = 8'd0;
        emit_st   = STAT_OK;
        adv       = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    kind_next     = s_axis_tuser;
                    tid_next      = s_axis_tdata[7:0];
                    per_next      = s_axis_tdata[23:8];
                    cnt_next      = s_axis_tdata[39:24];
                    slot_next     = '0;
                    found_next    = 1'b0;
                    fire_cnt_next = '0;
                    st_next       = STAT_OK;
                    tbl_next      = 2'((s_axis_tuser - 3'd1) >> 1);
                    if (s_axis_tuser == KIND_START_OS && s_axis_tdata[23:8] == 16'd1)
                    begin
                        per_next = 16'd2;
                    end
                    if (s_axis_tuser == KIND_TICK)
                    begin
                        tick_next      = tick_reg + 32'd1;
                        tbl_next       = TBL_OS;
                        tick_mode_next = 1'b1;
                        state_next     = S_SCAN_RD;
                    end
                    else if (s_axis_tuser == KIND_NONE)
                    begin
                        state_next = S_IDLE;
                    end
                    else if (s_axis_tdata[7:0] == 8'd0)
                    begin
                        st_next    = STAT_NULL;
                        state_next = S_STAT;
                    end
                    else if (s_axis_tuser == KIND_START_CT && s_axis_tdata[39:24] == 16'd0)
                    begin
                        st_next    = STAT_UNCHANGED;
                        state_next = S_STAT;
                    end
                    else if (s_axis_tuser == KIND_START_CT && s_axis_tdata[39:24] == 16'd1)
                    begin
                        state_next = S_RUN;
                    end
                    else
                    begin
                        tick_mode_next = 1'b0;
                        state_next     = S_SCAN_RD;
                    end
                end
            end

            S_SCAN_RD:
            begin
                if (cur_valid[slot_reg])
                begin
                    state_next = S_SCAN_EV;
                end
                else
                begin
                    adv = 1'b1;
                end
            end

            S_SCAN_EV:
            begin
                if (tick_mode_reg)
                begin
                    if (!expired)
                    begin
                        adv = 1'b1;
                    end
                    else if (fire_cnt_reg != FIRE_CNT_W'(MAX_RESULTS) && !can_emit)
                    begin
                        state_next = S_SCAN_EV;
                    end
                    else
                    begin
                        adv = 1'b1;
                        if (fire_cnt_reg != FIRE_CNT_W'(MAX_RESULTS))
                        begin
                            emit_en       = 1'b1;
                            emit_rk       = RK_FIRE;
                            emit_task     = cur_task;
                            fire_cnt_next = fire_cnt_reg + FIRE_CNT_W'(1);
                        end
                        case (tbl_reg)
                            TBL_OS:
                            begin
                                clr_en = 1'b1;
                            end
                            TBL_PD:
                            begin
                                wr_en = 1'b1;
                            end
                            default:
                            begin
                                wr_en   = 1'b1;
                                wr_data = {rem_dec, cur_task, cur_period, tick_reg};
                                clr_en  = (rem_dec == 16'd0);
                            end
                        endcase
                    end
                end
                else if (cur_task == tid_reg)
                begin
                    found_next        = 1'b1;
                    found_slot_next   = slot_reg;
                    found_period_next = cur_period;
                    found_rem_next    = cur_rem;
                    state_next        = S_ACT;
                end
                else
                begin
                    adv = 1'b1;
                end
            end

            S_ACT:
            begin
                state_next = S_STAT;
                clr_idx    = found_slot_reg;
                case (kind_reg)
                    KIND_START_OS:
                    begin
                        wr_data = {16'd0, tid_reg, per_reg, tick_reg};
                        if (found_reg)
                        begin
                            wr_en   = 1'b1;
                            wr_idx  = found_slot_reg;
                            wr_data = {16'd0, tid_reg, found_period_reg, tick_reg};
                        end
                        else if (free_ok)
                        begin
                            wr_en  = 1'b1;
                            wr_idx = free_idx;
                            set_en = 1'b1;
                        end
                        else
                        begin
                            st_next = STAT_FULL;
                        end
                    end
                    KIND_START_PD, KIND_START_CT:
                    begin
                        wr_data = {cnt_reg - 16'd1, tid_reg, per_reg, tick_reg};
                        if (found_reg && found_period_reg == per_reg &&
                            (kind_reg == KIND_START_PD || found_rem_reg == cnt_reg))
                        begin
                            st_next = STAT_UNCHANGED;
                        end
                        else
                        begin
                            clr_en = found_reg;
                            if (free_ok)
                            begin
                                wr_en      = 1'b1;
                                wr_idx     = free_idx;
                                set_en     = 1'b1;
                                state_next = S_RUN;
                            end
                            else
                            begin
                                st_next = STAT_FULL;
                            end
                        end
                    end
                    default:
                    begin
                        if (found_reg)
                        begin
                            clr_en = 1'b1;
                        end
                        else
                        begin
                            st_next = STAT_UNCHANGED;
                        end
                    end
                endcase
            end

            S_RUN:
            begin
                if (can_emit)
                begin
                    emit_en    = 1'b1;
                    emit_rk    = RK_RUN;
                    emit_task  = tid_reg;
                    state_next = S_STAT;
                end
            end

            S_STAT:
            begin
                if (can_emit)
                begin
                    emit_en    = 1'b1;
                    emit_rk    = RK_STATUS;
                    emit_st    = st_reg;
                    state_next = S_FIN;
                end
            end

            S_FIN:
            begin
                if (!pend_valid_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (out_free)
                begin
                    flush_en   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (adv)
        begin
            if (slot_reg == last_slot)
            begin
                slot_next = '0;
                if (tick_mode_reg && tbl_reg != TBL_CT)
                begin
                    tbl_next   = tbl_reg + 2'd1;
                    state_next = S_SCAN_RD;
                end
                else
                begin
                    state_next = tick_mode_reg ? S_FIN : S_ACT;
                end
            end
            else
            begin
                slot_next  = slot_reg + SLOT_W'(1);
                state_next = S_SCAN_RD;
            end
        end
    end

    // valid bit updates: clear first, then set
    always_comb
    begin
        os_valid_next = os_valid_reg;
        pd_valid_next = pd_valid_reg;
        ct_valid_next = ct_valid_reg;
        case (tbl_reg)
            TBL_OS:
            begin
                if (clr_en)
                begin
                    os_valid_next[clr_idx[OS_AW-1:0]] = 1'b0;
                end
                if (set_en)
                begin
                    os_valid_next[set_idx[OS_AW-1:0]] = 1'b1;
                end
            end
            TBL_PD:
            begin
                if (clr_en)
                begin
                    pd_valid_next[clr_idx[PD_AW-1:0]] = 1'b0;
                end
                if (set_en)
                begin
                    pd_valid_next[set_idx[PD_AW-1:0]] = 1'b1;
                end
            end
            default:
            begin
                if (clr_en)
                begin
                    ct_valid_next[clr_idx[CT_AW-1:0]] = 1'b0;
                end
                if (set_en)
                begin
                    ct_valid_next[set_idx[CT_AW-1:0]] = 1'b1;
                end
            end
        endcase
    end

    // result staging: the held result moves out when a newer one arrives or at the end
    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        pend_rk_next    = pend_rk_reg;
        pend_tbl_next   = pend_tbl_reg;
        pend_task_next  = pend_task_reg;
        pend_st_next    = pend_st_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_rk_next     = out_rk_reg;
        out_tbl_next    = out_tbl_reg;
        out_task_next   = out_task_reg;
        out_st_next     = out_st_reg;
        out_last_next   = out_last_reg;
        if ((emit_en || flush_en) && pend_valid_reg)
        begin
            out_valid_next = 1'b1;
            out_rk_next    = pend_rk_reg;
            out_tbl_next   = pend_tbl_reg;
            out_task_next  = pend_task_reg;
            out_st_next    = pend_st_reg;
            out_last_next  = flush_en;
            pend_valid_next = 1'b0;
        end
        if (emit_en)
        begin
            pend_valid_next = 1'b1;
            pend_rk_next    = emit_rk;
            pend_tbl_next   = emit_tbl;
            pend_task_next  = emit_task;
            pend_st_next    = emit_st;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            tick_reg       <= '0;
            os_valid_reg   <= '0;
            pd_valid_reg   <= '0;
            ct_valid_reg   <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            tick_mode_reg  <= 1'b0;
            fire_cnt_reg   <= '0;
            found_reg      <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            tick_reg       <= tick_next;
            os_valid_reg   <= os_valid_next;
            pd_valid_reg   <= pd_valid_next;
            ct_valid_reg   <= ct_valid_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            tick_mode_reg  <= tick_mode_next;
            fire_cnt_reg   <= fire_cnt_next;
            found_reg      <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg         <= kind_next;
        tid_reg          <= tid_next;
        per_reg          <= per_next;
        cnt_reg          <= cnt_next;
        tbl_reg          <= tbl_next;
        slot_reg         <= slot_next;
        found_slot_reg   <= found_slot_next;
        found_period_reg <= found_period_next;
        found_rem_reg    <= found_rem_next;
        st_reg           <= st_next;
        pend_rk_reg      <= pend_rk_next;
        pend_tbl_reg     <= pend_tbl_next;
        pend_task_reg    <= pend_task_next;
        pend_st_reg      <= pend_st_next;
        out_rk_reg       <= out_rk_next;
        out_tbl_reg      <= out_tbl_next;
        out_task_reg     <= out_task_next;
        out_st_reg       <= out_st_next;
        out_last_reg     <= out_last_next;
    end

    a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> !pend_valid_reg)
        else $error("result left staged while idle");

    a_fire_cap: assert property (@(posedge clk) disable iff (!rst_n)
        fire_cnt_reg <= FIRE_CNT_W'(MAX_RESULTS))
        else $error("fire count beyond result limit");

    a_tick_advance: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && s_axis_tuser == KIND_TICK |=> tick_reg == $past(tick_reg) + 32'd1)
        else $error("tick counter did not advance");

    a_emit_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        emit_en && pend_valid_reg |-> out_free)
        else $error("result staged over an occupied output");

endmodule
